FILE: rtl/core/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants for the particle pool update block.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int POOL_SIZE = 256;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  localparam int ACT_W  = 2;
  localparam int POS_W  = 24;
  localparam int VEL_W  = 16;
  localparam int LIFE_W = 8;
  localparam int RIDX_W = 8;
  localparam int SLOT_W = 8;
  localparam int LCNT_W = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic [LIFE_W-1:0]       life;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/ppu_ram.sv
// ----------------------------------------------------------------------------
// ppu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/ppu_alu.sv
// ----------------------------------------------------------------------------
// ppu_alu
// One Euler step for a particle: age, gravity on vy, saturating position add.
// ----------------------------------------------------------------------------
module ppu_alu (
  input  ppu_pkg::entry_t                     cur,
  input  logic signed [ppu_pkg::VEL_W-1:0]    gravity,
  output ppu_pkg::entry_t                     nxt,
  output logic                                expire
);
  import ppu_pkg::*;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic signed [VEL_W:0]   vy_sum;
  logic signed [VEL_W-1:0] vy_new;
  logic signed [POS_W:0]   x_sum;
  logic signed [POS_W:0]   y_sum;

  always_comb begin
    vy_sum = (VEL_W+1)'(cur.vy) + (VEL_W+1)'(gravity);
    if (vy_sum[VEL_W] != vy_sum[VEL_W-1]) begin
      vy_new = vy_sum[VEL_W] ? VEL_MIN : VEL_MAX;
    end else begin
      vy_new = vy_sum[VEL_W-1:0];
    end

    x_sum = (POS_W+1)'(cur.x) + (POS_W+1)'(cur.vx);
    y_sum = (POS_W+1)'(cur.y) + (POS_W+1)'(vy_new);

    nxt.vx   = cur.vx;
    nxt.vy   = vy_new;
    nxt.life = cur.life - LIFE_W'(1);
    if (x_sum[POS_W] != x_sum[POS_W-1]) begin
      nxt.x = x_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      nxt.x = x_sum[POS_W-1:0];
    end
    if (y_sum[POS_W] != y_sum[POS_W-1]) begin
      nxt.y = y_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      nxt.y = y_sum[POS_W-1:0];
    end

    expire = (cur.life <= LIFE_W'(1));
  end

endmodule

FILE: rtl/core/particle_pool_update.sv
// ----------------------------------------------------------------------------
// particle_pool_update
// Fixed pool of particles advanced by Euler steps, held in one RAM.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready, results leave on out_valid/out_ready,
// one result per request. gravity is written through cfg_wen/cfg_wdata.
// Live particles occupy slots 0 .. live_count-1 of a single-port-read RAM
// (one word per particle, registered read).
// add:  writes slot live_count at accept if the pool is not full.
// read: one RAM read at accept. Add, read and no-op go on to ST_FINISH.
// tick: reads slot 0 at accept if the pool is not empty, then handles one
//   RAM word per cycle: a survivor is written back while the next slot is
//   read; an expiring particle triggers a read of the last live slot, which
//   is then handled in its place. After the last live particle, or at once
//   on an empty pool, it moves to ST_FINISH, where the result is loaded.
// One request is in flight at a time; in_ready is high only when idle, so
// the next request is accepted in the cycle after the result is loaded.
// A stalled result holds in the output register and blocks the next one.
// Reset empties the pool and clears gravity; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module particle_pool_update (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic signed [ppu_pkg::VEL_W-1:0]      cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ppu_pkg::ACT_W-1:0]             action,
  input  logic signed [ppu_pkg::POS_W-1:0]      pos_x,
  input  logic signed [ppu_pkg::POS_W-1:0]      pos_y,
  input  logic signed [ppu_pkg::VEL_W-1:0]      vel_x,
  input  logic signed [ppu_pkg::VEL_W-1:0]      vel_y,
  input  logic [ppu_pkg::LIFE_W-1:0]            life,
  input  logic [ppu_pkg::RIDX_W-1:0]            read_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ppu_pkg::SLOT_W-1:0]            slot_index,
  output logic                                  pool_full,
  output logic [ppu_pkg::LCNT_W-1:0]            live_count,
  output logic                                  read_valid,
  output logic signed [ppu_pkg::POS_W-1:0]      out_pos_x,
  output logic signed [ppu_pkg::POS_W-1:0]      out_pos_y,
  output logic [ppu_pkg::LIFE_W-1:0]            out_life
);
  import ppu_pkg::*;

  state_t                   state, state_next;
  action_t                  act, act_next;
  logic [CNT_W-1:0]         live_total, live_total_next;
  logic [IDX_W-1:0]         idx, idx_next;
  logic [IDX_W-1:0]         slot, slot_next;
  logic                     full, full_next;
  logic                     rd_ok, rd_ok_next;
  logic signed [VEL_W-1:0]  gravity;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  entry_t                   ram_wdata;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;
  entry_t                   cur;
  entry_t                   upd;
  logic                     expire;
  logic [CNT_W-1:0]         live_dec;
  logic [CNT_W-1:0]         idx_inc;
  logic                     load_out;

  assign cur      = entry_t'(ram_rdata);
  assign live_dec = live_total - CNT_W'(1);
  assign idx_inc  = CNT_W'(idx) + CNT_W'(1);
  assign in_ready = (state == ST_IDLE);

  ppu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_SIZE),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppu_alu u_alu (
    .cur     (cur),
    .gravity (gravity),
    .nxt     (upd),
    .expire  (expire)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      live_total <= '0;
      gravity    <= '0;
    end else begin
      state      <= state_next;
      live_total <= live_total_next;
      if (cfg_wen) begin
        gravity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    act   <= act_next;
    idx   <= idx_next;
    slot  <= slot_next;
    full  <= full_next;
    rd_ok <= rd_ok_next;
  end

  always_comb begin
    state_next      = state;
    act_next        = act;
    live_total_next = live_total;
    idx_next        = idx;
    slot_next       = slot;
    full_next       = full;
    rd_ok_next      = rd_ok;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = upd;
    ram_re          = 1'b0;
    ram_raddr       = idx;
    load_out        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          act_next   = action_t'(action);
          state_next = ST_FINISH;
          unique case (action_t'(action))
            ACT_ADD: begin
              if (live_total < CNT_W'(POOL_SIZE)) begin
                ram_we          = 1'b1;
                ram_waddr       = live_total[IDX_W-1:0];
                ram_wdata.x     = pos_x;
                ram_wdata.y     = pos_y;
                ram_wdata.vx    = vel_x;
                ram_wdata.vy    = vel_y;
                ram_wdata.life  = life;
                slot_next       = live_total[IDX_W-1:0];
                full_next       = 1'b0;
                live_total_next = live_total + CNT_W'(1);
              end else begin
                full_next = 1'b1;
              end
            end
            ACT_TICK: begin
              if (live_total != '0) begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                idx_next   = '0;
                state_next = ST_TICK;
              end
            end
            ACT_READ: begin
              rd_ok_next = (int'(read_index) < int'(live_total));
              ram_re     = 1'b1;
              ram_raddr  = IDX_W'(read_index);
            end
            ACT_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_TICK: begin
        if (expire) begin
          // the last live particle, if not this one, takes this slot and is handled next cycle
          live_total_next = live_dec;
          if (CNT_W'(idx) < live_dec) begin
            ram_re    = 1'b1;
            ram_raddr = live_dec[IDX_W-1:0];
          end else begin
            state_next = ST_FINISH;
          end
        end else begin
          ram_we = 1'b1;
          if (idx_inc < live_total) begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[IDX_W-1:0];
            idx_next  = idx_inc[IDX_W-1:0];
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      slot_index <= (act == ACT_ADD && !full) ? SLOT_W'(slot) : '0;
      pool_full  <= (act == ACT_ADD) && full;
      live_count <= LCNT_W'(live_total);
      read_valid <= (act == ACT_READ) && rd_ok;
      if (act == ACT_READ && rd_ok) begin
        out_pos_x <= cur.x;
        out_pos_y <= cur.y;
        out_life  <= cur.life;
      end else begin
        out_pos_x <= '0;
        out_pos_y <= '0;
        out_life  <= '0;
      end
    end
  end

endmodule

FILE: rtl/core/ppu_checker.sv
// ----------------------------------------------------------------------------
// ppu_checker
// Port-level checks for particle_pool_update, bound to the top level.
// ----------------------------------------------------------------------------
module ppu_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [ppu_pkg::SLOT_W-1:0]            slot_index,
  input  logic                                  pool_full,
  input  logic [ppu_pkg::LCNT_W-1:0]            live_count,
  input  logic                                  read_valid,
  input  logic signed [ppu_pkg::POS_W-1:0]      out_pos_x,
  input  logic signed [ppu_pkg::POS_W-1:0]      out_pos_y,
  input  logic [ppu_pkg::LIFE_W-1:0]            out_life
);
  import ppu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(live_count) && $stable(slot_index))
    else $error("result changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && pool_full |-> slot_index == '0 && live_count == LCNT_W'(POOL_SIZE)
      && !read_valid)
    else $error("refused add with pool not full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(live_count) <= POOL_SIZE)
    else $error("live count above pool size");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> out_pos_x == '0 && out_pos_y == '0 && out_life == '0)
    else $error("read data without valid read");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> live_count != '0 && slot_index == '0)
    else $error("valid read from empty pool");

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (.*);

FILE: tb/particle_pool_update_test.sv
// ----------------------------------------------------------------------------
// particle_pool_update_test
// Self-checking bench for the particle pool: add, tick, read and no-op
// requests are driven over valid/ready. A scoreboard keeps its own copy of
// the pool and the gravity setting, predicts each result and compares it
// field by field. Runs a directed opening, a fill to a full pool, then
// random phases at several gravity settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module particle_pool_update_test;
  import ppu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_MAX     = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN     = -(2 ** (POS_W - 1));
  localparam int VEL_MAX     = 2 ** (VEL_W - 1) - 1;
  localparam int VEL_MIN     = -(2 ** (VEL_W - 1));
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 110;

  typedef struct packed {
    action_t                  act;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
    logic [LIFE_W-1:0]        life;
    logic [RIDX_W-1:0]        ridx;
  } pool_request_t;

  typedef struct packed {
    logic [SLOT_W-1:0]        slot_index;
    logic                     pool_full;
    logic [LCNT_W-1:0]        live_count;
    logic                     read_valid;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [LIFE_W-1:0]        life;
  } pool_result_t;

  class pool_scoreboard;
    logic signed [POS_W-1:0] slot_x    [POOL_SIZE];
    logic signed [POS_W-1:0] slot_y    [POOL_SIZE];
    logic signed [VEL_W-1:0] slot_vx   [POOL_SIZE];
    logic signed [VEL_W-1:0] slot_vy   [POOL_SIZE];
    logic [LIFE_W-1:0]       slot_life [POOL_SIZE];
    int                      live;
    logic signed [VEL_W-1:0] grav;
    pool_result_t            expected_q[$];
    int mismatches, checked, n_add, n_full, n_tick, n_read, n_hit, n_nop;
    int n_expired, n_moved, n_vel_clamp, n_pos_clamp, peak_live;

    function void set_gravity(logic signed [VEL_W-1:0] g);
      grav = g;
    endfunction

    function logic signed [VEL_W-1:0] clamp_vel(int v);
      if (v > VEL_MAX || v < VEL_MIN) n_vel_clamp++;
      if (v > VEL_MAX) return VEL_W'(VEL_MAX);
      if (v < VEL_MIN) return VEL_W'(VEL_MIN);
      return VEL_W'(v);
    endfunction

    function logic signed [POS_W-1:0] clamp_pos(int v);
      if (v > POS_MAX || v < POS_MIN) n_pos_clamp++;
      if (v > POS_MAX) return POS_W'(POS_MAX);
      if (v < POS_MIN) return POS_W'(POS_MIN);
      return POS_W'(v);
    endfunction

    // Euler step over the live slots; an expiring slot takes the last live
    // particle and is handled again.
    function void advance_pool();
      int i;
      i = 0;
      while (i < live) begin
        if (slot_life[i] <= 1) begin
          live--;
          n_expired++;
          if (i != live) begin
            slot_x[i]    = slot_x[live];
            slot_y[i]    = slot_y[live];
            slot_vx[i]   = slot_vx[live];
            slot_vy[i]   = slot_vy[live];
            slot_life[i] = slot_life[live];
            n_moved++;
          end
        end else begin
          slot_life[i] = slot_life[i] - 1'b1;
          slot_vy[i]   = clamp_vel(int'(slot_vy[i]) + int'(grav));
          slot_x[i]    = clamp_pos(int'(slot_x[i]) + int'(slot_vx[i]));
          slot_y[i]    = clamp_pos(int'(slot_y[i]) + int'(slot_vy[i]));
          i++;
        end
      end
    endfunction

    function void note_request(pool_request_t rq);
      pool_result_t want;
      want = '0;
      case (rq.act)
        ACT_ADD: begin
          n_add++;
          if (live >= POOL_SIZE) begin
            want.pool_full = 1'b1;
            n_full++;
          end else begin
            slot_x[live]    = rq.x;
            slot_y[live]    = rq.y;
            slot_vx[live]   = rq.vx;
            slot_vy[live]   = rq.vy;
            slot_life[live] = rq.life;
            want.slot_index = SLOT_W'(live);
            live++;
          end
        end
        ACT_TICK: begin
          n_tick++;
          advance_pool();
        end
        ACT_READ: begin
          n_read++;
          if (rq.ridx < live) begin
            n_hit++;
            want.read_valid = 1'b1;
            want.pos_x      = slot_x[rq.ridx];
            want.pos_y      = slot_y[rq.ridx];
            want.life       = slot_life[rq.ridx];
          end
        end
        default: n_nop++;
      endcase
      want.live_count = LCNT_W'(live);
      if (live > peak_live) peak_live = live;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request pending (live_count %0d)", got.live_count);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
      compare_field("pool_full", 32'(want.pool_full), 32'(got.pool_full));
      compare_field("live_count", 32'(want.live_count), 32'(got.live_count));
      compare_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
      compare_field("out_pos_x", 32'(want.pos_x), 32'(got.pos_x));
      compare_field("out_pos_y", 32'(want.pos_y), 32'(got.pos_y));
      compare_field("out_life", 32'(want.life), 32'(got.life));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_wen;
  logic signed [VEL_W-1:0]  cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACT_W-1:0]         action;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [VEL_W-1:0]  vel_x;
  logic signed [VEL_W-1:0]  vel_y;
  logic [LIFE_W-1:0]        life;
  logic [RIDX_W-1:0]        read_index;
  logic                     out_valid;
  logic                     out_ready;
  logic [SLOT_W-1:0]        slot_index;
  logic                     pool_full;
  logic [LCNT_W-1:0]        live_count;
  logic                     read_valid;
  logic signed [POS_W-1:0]  out_pos_x;
  logic signed [POS_W-1:0]  out_pos_y;
  logic [LIFE_W-1:0]        out_life;

  pool_scoreboard sb = new();
  int             idle_pct;
  int             stall_pct;
  int             hold_off_req;
  int             hold_left;
  int unsigned    cycle_count;

  particle_pool_update dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .life       (life),
    .read_index (read_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .slot_index (slot_index),
    .pool_full  (pool_full),
    .live_count (live_count),
    .read_valid (read_valid),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_life   (out_life)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pool_request_t make_request(action_t a, int x, int y, int vx,
                                                 int vy, int lf, int ridx);
    pool_request_t rq;
    rq.act  = a;
    rq.x    = POS_W'(x);
    rq.y    = POS_W'(y);
    rq.vx   = VEL_W'(vx);
    rq.vy   = VEL_W'(vy);
    rq.life = LIFE_W'(lf);
    rq.ridx = RIDX_W'(ridx);
    return rq;
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(0, 5))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return int'($urandom_range(0, 4095)) - 2048;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int rand_vel();
    case ($urandom_range(0, 5))
      0:       return VEL_MAX;
      1:       return VEL_MIN;
      2:       return int'($urandom_range(0, 1023)) - 512;
      default: return int'($urandom);
    endcase
  endfunction

  // mostly short lives so the pool churns, with zero and the longest mixed in
  function automatic int rand_life();
    case ($urandom_range(0, 7))
      0:          return 0;
      1:          return 255;
      2, 3, 4, 5: return $urandom_range(1, 12);
      default:    return $urandom_range(1, 255);
    endcase
  endfunction

  function automatic pool_request_t random_request(int live_now);
    pool_request_t rq;
    int pick;
    rq = make_request(ACT_ADD, rand_pos(), rand_pos(), rand_vel(), rand_vel(),
                      rand_life(), $urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 45)      rq.act = ACT_ADD;
    else if (pick < 67) rq.act = ACT_TICK;
    else if (pick < 96) rq.act = ACT_READ;
    else                rq.act = ACT_NOP;
    if (rq.act == ACT_READ && live_now > 0 && $urandom_range(0, 3) != 0)
      rq.ridx = RIDX_W'($urandom_range(0, live_now - 1));
    return rq;
  endfunction

  task automatic send_item(pool_request_t rq);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= rq.act;
    pos_x      <= rq.x;
    pos_y      <= rq.y;
    vel_x      <= rq.vx;
    vel_y      <= rq.vy;
    life       <= rq.life;
    read_index <= rq.ridx;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_gravity(logic signed [VEL_W-1:0] g);
    cfg_wen   <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.set_gravity(g);
  endtask

  // result side: check, then pick next ready (random stall or long hold-off)
  initial begin
    pool_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.slot_index = slot_index;
        got.pool_full  = pool_full;
        got.live_count = live_count;
        got.read_valid = read_valid;
        got.pos_x      = out_pos_x;
        got.pos_y      = out_pos_y;
        got.life       = out_life;
        sb.check_result(got);
      end
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d requests still pending",
             cycle_count, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic signed [VEL_W-1:0] g;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_off_req = 0;
    hold_left    = 0;
    rst        <= 1'b1;
    cfg_wen    <= 1'b0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    out_ready  <= 1'b1;
    action     <= ACT_NOP;
    pos_x      <= '0;
    pos_y      <= '0;
    vel_x      <= '0;
    vel_y      <= '0;
    life       <= '0;
    read_index <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait_drained();
    write_gravity('0);

    // directed opening on an empty pool, then four particles, the first two at the extremes
    send_item(make_request(ACT_READ, 0, 0, 0, 0, 0, 0));
    send_item(make_request(ACT_READ, 0, 0, 0, 0, 0, 255));
    send_item(make_request(ACT_NOP, 0, 0, 0, 0, 0, 0));
    send_item(make_request(ACT_TICK, 0, 0, 0, 0, 0, 0));
    send_item(make_request(ACT_ADD, POS_MAX, POS_MIN, VEL_MAX, VEL_MIN, 255, 0));
    send_item(make_request(ACT_ADD, POS_MIN, POS_MAX, VEL_MIN, VEL_MAX, 1, 0));
    send_item(make_request(ACT_ADD, 0, 0, 256, -256, 0, 0));
    send_item(make_request(ACT_ADD, 'h123456, -'h54321, 'h0100, -'h0080, 3, 0));
    for (int r = 0; r <= 4; r++)
      send_item(make_request(ACT_READ, 0, 0, 0, 0, 0, r));
    // life-1 expires and the last one moves in; the zero-life one is last
    send_item(make_request(ACT_TICK, 0, 0, 0, 0, 0, 0));
    for (int r = 0; r <= 2; r++)
      send_item(make_request(ACT_READ, 0, 0, 0, 0, 0, r));
    send_item(make_request(ACT_TICK, 0, 0, 0, 0, 0, 0));
    send_item(make_request(ACT_TICK, 0, 0, 0, 0, 0, 0));
    send_item(make_request(ACT_READ, 0, 0, 0, 0, 0, 1));
    send_item(make_request(ACT_READ, 0, 0, 0, 0, 0, 0));
    send_item(make_request(ACT_NOP, POS_MIN, POS_MAX, VEL_MIN, VEL_MAX, 255, 255));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin g = VEL_W'($urandom_range(0, 128) - 64); idle_pct = 0; stall_pct = 0; end
        1: begin g = VEL_W'(VEL_MAX);               idle_pct = 53; stall_pct = 0;  end
        2: begin g = VEL_W'(VEL_MIN);               idle_pct = 0;  stall_pct = 53; end
        3: begin g = VEL_W'($urandom);              idle_pct = 38; stall_pct = 38; end
        4: begin g = '0;                            idle_pct = 0;  stall_pct = 0;  end
        default: begin
          g = VEL_W'($urandom_range(0, 512) - 256);
          idle_pct  = 38;
          stall_pct = 38;
        end
      endcase
      write_gravity(g);

      if (ph == 0) begin
        // fill to the top, try a few refused adds, then tick a full pool
        while (sb.live < POOL_SIZE)
          send_item(make_request(ACT_ADD, rand_pos(), rand_pos(), rand_vel(),
                                 rand_vel(), rand_life(), $urandom));
        repeat (3)
          send_item(make_request(ACT_ADD, rand_pos(), rand_pos(), rand_vel(),
                                 rand_vel(), rand_life(), $urandom));
        send_item(make_request(ACT_READ, 0, 0, 0, 0, 0, POOL_SIZE - 1));
        send_item(make_request(ACT_TICK, 0, 0, 0, 0, 0, 0));
        send_item(make_request(ACT_READ, 0, 0, 0, 0, 0, $urandom_range(0, 255)));
      end
      if (ph == 2) hold_off_req = 300;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) wait_drained();
        send_item(random_request(sb.live));
      end
    end

    wait_drained();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (2 * POOL_SIZE + 16) @(posedge clk);

    $display("Covered %0d adds (%0d refused, full), %0d ticks, %0d reads (%0d in range),",
             sb.n_add, sb.n_full, sb.n_tick, sb.n_read, sb.n_hit);
    $display("%0d no-ops, peak live %0d, %0d expired, %0d moved, %0d/%0d vel/pos clamps",
             sb.n_nop, sb.peak_live, sb.n_expired, sb.n_moved, sb.n_vel_clamp,
             sb.n_pos_clamp);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
